// ===== rtl/kfc_pkg.sv =====
// Package for the keypad four-function calculator.
// Holds the key map, key and status codes, and the scan transaction type.
// No dependencies; every other file refers to it by scoped names.
package kfc_pkg;

    localparam int DATA_WIDTH_DEFAULT = 32;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [3:0] DIGIT_LIMIT = 4'hA;
    localparam logic [3:0] KEY_ADD = 4'hA;
    localparam logic [3:0] KEY_SUB = 4'hB;
    localparam logic [3:0] KEY_MUL = 4'hC;
    localparam logic [3:0] KEY_DIV = 4'hD;

    localparam logic [1:0] ERR_NONE = 2'd0;
    localparam logic [1:0] ERR_DIV_ZERO = 2'd1;
    localparam logic [1:0] ERR_BAD_OP = 2'd2;

    localparam logic [1:0] CH_ADD = 2'd0;
    localparam logic [1:0] CH_SUB = 2'd1;
    localparam logic [1:0] CH_MUL = 2'd2;
    localparam logic [1:0] CH_DIV = 2'd3;

    // Key code by matrix bit, where the bit index is column*4+row.
    localparam logic [3:0] KEY_BY_BIT [16] = '{
        4'hD, 4'hC, 4'hB, 4'hA,
        4'hE, 4'h9, 4'h6, 4'h3,
        4'hF, 4'h8, 4'h5, 4'h2,
        4'h0, 4'h7, 4'h4, 4'h1
    };

    typedef struct packed {
        logic       pressed_valid;
        logic [3:0] pressed_key;
        logic       released_valid;
        logic [3:0] released_key;
    } scan_evt_t;

endpackage

// ===== rtl/keypad_four_function_calculator_unit.sv =====
// Top level of the keypad four-function calculator.
// Instantiates kfc_front, kfc_queue and kfc_back; uses kfc_pkg.
//
//   Channel   Handshake                    Payload
//   scan      scan_valid / scan_ready      key_matrix
//   report    report_valid / report_ready  pressed_*, released_*, result_*,
//                                          error_code, op_channel
//
// Every scan transaction yields exactly one report transaction, in order.
// A scan that only moves a key or an operand passes through the queue slot and
// the output register in kfc_back, and while report_ready is high and no loop
// runs the calculator sustains one per cycle; add, subtract and errors cost the
// same. Multiply and divide run a shift-add or restoring-divide loop in kfc_back,
// one bit per cycle, before their report is registered as valid.
// Reset is asynchronous and clears key, operand and operator state at once.
// A two-entry queue keeps scans coming while report_ready is low or a loop runs.
module keypad_four_function_calculator_unit #(
    parameter int DATA_WIDTH = kfc_pkg::DATA_WIDTH_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        scan_valid,
    output logic        scan_ready,
    input  logic [15:0] key_matrix,
    output logic        report_valid,
    input  logic        report_ready,
    output logic        pressed_valid,
    output logic [3:0]  pressed_key,
    output logic        released_valid,
    output logic [3:0]  released_key,
    output logic        result_valid,
    output logic [31:0] result_value,
    output logic [1:0]  error_code,
    output logic [1:0]  op_channel
);

    logic               push;
    logic               q_ready;
    logic               q_valid;
    logic               q_pop;
    kfc_pkg::scan_evt_t push_evt;
    kfc_pkg::scan_evt_t q_evt;

    kfc_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .scan_valid (scan_valid),
        .scan_ready (scan_ready),
        .key_matrix (key_matrix),
        .q_ready    (q_ready),
        .push       (push),
        .evt        (push_evt)
    );

    kfc_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_evt (push_evt),
        .q_ready  (q_ready),
        .pop      (q_pop),
        .q_valid  (q_valid),
        .q_evt    (q_evt)
    );

    kfc_back #(
        .DataW (DATA_WIDTH)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .q_valid        (q_valid),
        .q_evt          (q_evt),
        .q_pop          (q_pop),
        .report_valid   (report_valid),
        .report_ready   (report_ready),
        .pressed_valid  (pressed_valid),
        .pressed_key    (pressed_key),
        .released_valid (released_valid),
        .released_key   (released_key),
        .result_valid   (result_valid),
        .result_value   (result_value),
        .error_code     (error_code),
        .op_channel     (op_channel)
    );

endmodule

// ===== rtl/kfc_front.sv =====
// Scan front end: picks the pressed key, tracks the held key, detects release.
// Depends on kfc_pkg; feeds kfc_queue with one scan_evt_t per transaction.
module kfc_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                scan_valid,
    output logic                scan_ready,
    input  logic [15:0]         key_matrix,
    input  logic                q_ready,
    output logic                push,
    output kfc_pkg::scan_evt_t  evt
);

    logic       held_valid_reg;
    logic [3:0] held_key_reg;
    logic       pv;
    logic [3:0] idx;
    logic [3:0] pk;

    always_comb
    begin
        pv  = 1'b0;
        idx = 4'd0;
        for (int i = 0; i < 16; i++)
        begin
            if (key_matrix[i])
            begin
                pv  = 1'b1;
                idx = 4'(i);
            end
        end
        pk = pv ? kfc_pkg::KEY_BY_BIT[idx] : 4'd0;
    end

    assign scan_ready = q_ready;
    assign push = scan_valid && q_ready;

    always_comb
    begin
        evt.pressed_valid  = pv;
        evt.pressed_key    = pk;
        evt.released_valid = !pv && held_valid_reg;
        evt.released_key   = (!pv && held_valid_reg) ? held_key_reg : 4'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_valid_reg <= 1'b0;
            held_key_reg   <= 4'd0;
        end
        else if (push)
        begin
            held_valid_reg <= pv;
            held_key_reg   <= pk;
        end
    end

endmodule

// ===== rtl/kfc_queue.sv =====
// Short queue of scan transactions between the front end and the calculator.
// Depends on kfc_pkg for the transaction type and the depth.
module kfc_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  kfc_pkg::scan_evt_t  push_evt,
    output logic                q_ready,
    input  logic                pop,
    output logic                q_valid,
    output kfc_pkg::scan_evt_t  q_evt
);

    localparam int Depth = kfc_pkg::QUEUE_DEPTH;
    localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int CntW = $clog2(Depth + 1);

    kfc_pkg::scan_evt_t  slot_reg [Depth];
    logic [PtrW-1:0]     wr_ptr_reg;
    logic [PtrW-1:0]     rd_ptr_reg;
    logic [CntW-1:0]     count_reg;

    assign q_ready = count_reg != CntW'(Depth);
    assign q_valid = count_reg != '0;
    assign q_evt   = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_evt;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PtrW'(Depth - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PtrW'(Depth - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// ===== rtl/kfc_back.sv =====
// Calculator back end: operand entry, operator handling, iterative multiply
// and divide, and the output register. Depends on kfc_pkg.
module kfc_back #(
    parameter int DataW = kfc_pkg::DATA_WIDTH_DEFAULT
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_valid,
    input  kfc_pkg::scan_evt_t  q_evt,
    output logic                q_pop,
    output logic                report_valid,
    input  logic                report_ready,
    output logic                pressed_valid,
    output logic [3:0]          pressed_key,
    output logic                released_valid,
    output logic [3:0]          released_key,
    output logic                result_valid,
    output logic [31:0]         result_value,
    output logic [1:0]          error_code,
    output logic [1:0]          op_channel
);

    localparam int CntW = $clog2(DataW);

    typedef enum logic {ST_IDLE, ST_CALC} state_t;

    state_t             state_reg, state_next;
    logic               phase_reg, phase_next;
    logic [DataW-1:0]   first_reg, first_next;
    logic [DataW-1:0]   second_reg, second_next;
    logic [3:0]         opcode_reg, opcode_next;
    logic [DataW-1:0]   acc_reg, acc_next;
    logic [DataW-1:0]   shf_reg, shf_next;
    logic [DataW-1:0]   opb_reg, opb_next;
    logic               is_div_reg, is_div_next;
    logic [CntW-1:0]    cnt_reg, cnt_next;
    logic               out_valid_reg, out_valid_next;
    logic               pv_reg, pv_next;
    logic [3:0]         pk_reg, pk_next;
    logic               rv_reg, rv_next;
    logic [3:0]         rk_reg, rk_next;
    logic               resv_reg, resv_next;
    logic [31:0]        resval_reg, resval_next;
    logic [1:0]         err_reg, err_next;
    logic [1:0]         ch_reg, ch_next;

    logic               slot_free;
    logic [DataW-1:0]   mul_acc;
    logic [DataW:0]     div_trial;
    logic [DataW:0]     div_diff;
    logic               div_ge;
    logic [DataW-1:0]   div_rem;
    logic [DataW-1:0]   div_quo;
    logic [DataW-1:0]   step_acc;
    logic [DataW-1:0]   step_shf;
    logic [DataW-1:0]   step_opb;

    function automatic logic [31:0] to_result(input logic [DataW-1:0] v);
        logic [63:0] wide;
        wide = 64'(v);
        return wide[31:0];
    endfunction

    assign slot_free = !out_valid_reg || report_ready;
    assign q_pop = (state_reg == ST_IDLE) && q_valid && slot_free;

    // One step of shift-add multiply or restoring divide.
    always_comb
    begin
        mul_acc   = opb_reg[0] ? acc_reg + shf_reg : acc_reg;
        div_trial = {acc_reg, shf_reg[DataW-1]};
        div_diff  = div_trial - {1'b0, opb_reg};
        div_ge    = div_trial >= {1'b0, opb_reg};
        div_rem   = div_ge ? div_diff[DataW-1:0] : div_trial[DataW-1:0];
        div_quo   = {shf_reg[DataW-2:0], div_ge};
        if (is_div_reg)
        begin
            step_acc = div_rem;
            step_shf = div_quo;
            step_opb = opb_reg;
        end
        else
        begin
            step_acc = mul_acc;
            step_shf = shf_reg << 1;
            step_opb = opb_reg >> 1;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        phase_next     = phase_reg;
        first_next     = first_reg;
        second_next    = second_reg;
        opcode_next    = opcode_reg;
        acc_next       = acc_reg;
        shf_next       = shf_reg;
        opb_next       = opb_reg;
        is_div_next    = is_div_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg && !report_ready;
        pv_next        = pv_reg;
        pk_next        = pk_reg;
        rv_next        = rv_reg;
        rk_next        = rk_reg;
        resv_next      = resv_reg;
        resval_next    = resval_reg;
        err_next       = err_reg;
        ch_next        = ch_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (q_pop)
                begin
                    pv_next        = q_evt.pressed_valid;
                    pk_next        = q_evt.pressed_key;
                    rv_next        = q_evt.released_valid;
                    rk_next        = q_evt.released_key;
                    resv_next      = 1'b0;
                    resval_next    = '0;
                    err_next       = kfc_pkg::ERR_NONE;
                    ch_next        = kfc_pkg::CH_ADD;
                    out_valid_next = 1'b1;
                    if (q_evt.released_valid)
                    begin
                        if (q_evt.released_key < kfc_pkg::DIGIT_LIMIT)
                        begin
                            if (!phase_reg)
                            begin
                                first_next = (first_reg << 3) + (first_reg << 1)
                                    + DataW'(q_evt.released_key);
                            end
                            else
                            begin
                                second_next = (second_reg << 3) + (second_reg << 1)
                                    + DataW'(q_evt.released_key);
                            end
                        end
                        else if (!phase_reg)
                        begin
                            opcode_next = q_evt.released_key;
                            second_next = '0;
                            phase_next  = 1'b1;
                        end
                        else
                        begin
                            phase_next  = 1'b0;
                            first_next  = '0;
                            second_next = '0;
                            resv_next   = 1'b1;
                            case (opcode_reg)
                                kfc_pkg::KEY_ADD:
                                begin
                                    resval_next = to_result(first_reg + second_reg);
                                    ch_next     = kfc_pkg::CH_ADD;
                                end
                                kfc_pkg::KEY_SUB:
                                begin
                                    resval_next = to_result(first_reg - second_reg);
                                    ch_next     = kfc_pkg::CH_SUB;
                                end
                                kfc_pkg::KEY_MUL:
                                begin
                                    out_valid_next = 1'b0;
                                    acc_next       = '0;
                                    shf_next       = first_reg;
                                    opb_next       = second_reg;
                                    is_div_next    = 1'b0;
                                    cnt_next       = CntW'(DataW - 1);
                                    state_next     = ST_CALC;
                                end
                                kfc_pkg::KEY_DIV:
                                begin
                                    if (second_reg == '0)
                                    begin
                                        resval_next = to_result('1);
                                        err_next    = kfc_pkg::ERR_DIV_ZERO;
                                    end
                                    else
                                    begin
                                        out_valid_next = 1'b0;
                                        acc_next       = '0;
                                        shf_next       = first_reg;
                                        opb_next       = second_reg;
                                        is_div_next    = 1'b1;
                                        cnt_next       = CntW'(DataW - 1);
                                        state_next     = ST_CALC;
                                    end
                                end
                                default:
                                begin
                                    resval_next = to_result('1);
                                    err_next    = kfc_pkg::ERR_BAD_OP;
                                end
                            endcase
                        end
                    end
                end
            end
            ST_CALC:
            begin
                acc_next = step_acc;
                shf_next = step_shf;
                opb_next = step_opb;
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    out_valid_next = 1'b1;
                    resval_next    = to_result(is_div_reg ? step_shf : step_acc);
                    ch_next        = is_div_reg ? kfc_pkg::CH_DIV : kfc_pkg::CH_MUL;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            phase_reg     <= 1'b0;
            first_reg     <= '0;
            second_reg    <= '0;
            opcode_reg    <= 4'd0;
            acc_reg       <= '0;
            shf_reg       <= '0;
            opb_reg       <= '0;
            is_div_reg    <= 1'b0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
            pv_reg        <= 1'b0;
            pk_reg        <= 4'd0;
            rv_reg        <= 1'b0;
            rk_reg        <= 4'd0;
            resv_reg      <= 1'b0;
            resval_reg    <= '0;
            err_reg       <= kfc_pkg::ERR_NONE;
            ch_reg        <= kfc_pkg::CH_ADD;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            first_reg     <= first_next;
            second_reg    <= second_next;
            opcode_reg    <= opcode_next;
            acc_reg       <= acc_next;
            shf_reg       <= shf_next;
            opb_reg       <= opb_next;
            is_div_reg    <= is_div_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
            pv_reg        <= pv_next;
            pk_reg        <= pk_next;
            rv_reg        <= rv_next;
            rk_reg        <= rk_next;
            resv_reg      <= resv_next;
            resval_reg    <= resval_next;
            err_reg       <= err_next;
            ch_reg        <= ch_next;
        end
    end

    assign report_valid   = out_valid_reg;
    assign pressed_valid  = pv_reg;
    assign pressed_key    = pk_reg;
    assign released_valid = rv_reg;
    assign released_key   = rk_reg;
    assign result_valid   = resv_reg;
    assign result_value   = resval_reg;
    assign error_code     = err_reg;
    assign op_channel     = ch_reg;

endmodule

// ===== rtl/kfc_checker.sv =====
// Port-level checker for the keypad calculator and its bind statement.
// Depends on kfc_pkg and attaches to keypad_four_function_calculator_unit.
module kfc_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        report_valid,
    input logic        report_ready,
    input logic        pressed_valid,
    input logic [3:0]  pressed_key,
    input logic        released_valid,
    input logic [3:0]  released_key,
    input logic        result_valid,
    input logic [31:0] result_value,
    input logic [1:0]  error_code,
    input logic [1:0]  op_channel
);

    a_report_hold: assert property (@(posedge clk) disable iff (!rst_n)
        report_valid && !report_ready |=> report_valid && $stable(result_value)
            && $stable(released_key))
        else $error("report transaction changed while stalled");

    a_idle_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
        report_valid && !result_valid |->
            result_value == 32'd0 && error_code == kfc_pkg::ERR_NONE
            && op_channel == kfc_pkg::CH_ADD)
        else $error("result fields set without a result");

    a_error_channel: assert property (@(posedge clk) disable iff (!rst_n)
        report_valid && error_code != kfc_pkg::ERR_NONE |->
            op_channel == kfc_pkg::CH_ADD && error_code != 2'd3)
        else $error("bad error code or channel on error");

    a_release_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        report_valid |-> !(released_valid && pressed_valid)
            && (pressed_valid || pressed_key == 4'd0)
            && (released_valid || released_key == 4'd0))
        else $error("pressed and released keys inconsistent");

    a_result_needs_operator: assert property (@(posedge clk) disable iff (!rst_n)
        report_valid && result_valid |->
            released_valid && released_key >= kfc_pkg::DIGIT_LIMIT)
        else $error("result without a released operator key");

endmodule

bind keypad_four_function_calculator_unit kfc_checker u_kfc_checker (.*);
